// File: design/kcd_pkg.sv
package kcd_pkg;

    localparam int unsigned LETTERS  = 26;
    localparam int unsigned IDX_W    = 5;
    localparam logic [7:0]  UPPER_A  = 8'd65;
    localparam logic [7:0]  LOWER_A  = 8'd97;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);

    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_END  = 2'd1,
        MODE_MSG  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic             key_load;
        logic             msg_load;
        logic             walk_step;
        logic             walk_last;
        logic [IDX_W-1:0] walk_idx;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_full;
        logic table_ready;
    } t_stat;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_fold;

    // letter of either case -> index 0..25
    function automatic t_fold fold_letter(input logic [7:0] c);
        t_fold      f;
        logic [7:0] du;
        logic [7:0] dl;
        du    = c - UPPER_A;
        dl    = c - LOWER_A;
        f.hit = 1'b0;
        f.idx = '0;
        if (c >= UPPER_A && c < UPPER_A + 8'(LETTERS)) begin
            f.hit = 1'b1;
            f.idx = du[IDX_W-1:0];
        end else if (c >= LOWER_A && c < LOWER_A + 8'(LETTERS)) begin
            f.hit = 1'b1;
            f.idx = dl[IDX_W-1:0];
        end
        return f;
    endfunction

endpackage

// File: design/kcd_ctrl.sv
module kcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic [1:0]    s_axis_tuser,
    output logic          s_axis_tready,
    input  logic          m_axis_tready,
    input  kcd_pkg::t_stat i_stat,
    output kcd_pkg::t_cmd  o_cmd
);
    import kcd_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_walk, n_walk;
    logic             accept;
    t_mode            mode;

    assign mode   = t_mode'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_walk  = r_walk;
        case (r_state)
            ST_IDLE: begin
                n_walk = '0;
                if (accept && mode == MODE_END) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_walk == LAST_IDX) begin
                    n_state = ST_IDLE;
                    n_walk  = '0;
                end else begin
                    n_walk = r_walk + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_walk  = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready   = 1'b0;
        o_cmd           = '0;
        o_cmd.walk_idx  = r_walk;
        case (r_state)
            ST_IDLE: begin
                // a word may enter while the output slot is empty or being taken by the sink
                s_axis_tready  = !i_stat.out_full || m_axis_tready;
                o_cmd.key_load = s_axis_tvalid && s_axis_tready && mode == MODE_KEY;
                o_cmd.msg_load = s_axis_tvalid && s_axis_tready && mode == MODE_MSG;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.walk_last = r_walk == LAST_IDX;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/kcd_dpath.sv
module kcd_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kcd_pkg::t_cmd i_cmd,
    input  logic [7:0]    s_axis_tdata,
    input  logic          m_axis_tready,
    output logic          m_axis_tvalid,
    output logic [7:0]    m_axis_tdata,
    output logic          m_axis_tuser,
    output kcd_pkg::t_stat o_stat
);
    import kcd_pkg::*;

    logic [LETTERS-1:0] r_used, n_used;
    logic [IDX_W-1:0]   r_count, n_count;
    logic               r_ready, n_ready;
    logic [IDX_W-1:0]   r_pos [LETTERS];
    logic               pos_we;
    logic [IDX_W-1:0]   pos_waddr;
    logic [IDX_W-1:0]   pos_wdata;

    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_nr;

    t_fold              fold;
    logic [LETTERS-1:0] used_base;
    logic [IDX_W-1:0]   count_base;
    logic [7:0]         dec_char;

    assign fold = fold_letter(s_axis_tdata);

    // a key byte after a finished table starts over
    assign used_base  = r_ready ? '0 : r_used;
    assign count_base = r_ready ? '0 : r_count;

    always_comb begin
        n_used    = r_used;
        n_count   = r_count;
        n_ready   = r_ready;
        pos_we    = 1'b0;
        pos_waddr = i_cmd.walk_idx;
        pos_wdata = r_count;
        if (i_cmd.key_load) begin
            n_used  = used_base;
            n_count = count_base;
            n_ready = 1'b0;
            if (fold.hit && !used_base[fold.idx]) begin
                pos_we          = 1'b1;
                pos_waddr       = fold.idx;
                pos_wdata       = count_base;
                n_used[fold.idx] = 1'b1;
                n_count         = count_base + IDX_W'(1);
            end
        end else if (i_cmd.walk_step) begin
            if (!r_used[i_cmd.walk_idx]) begin
                pos_we                 = 1'b1;
                n_used[i_cmd.walk_idx] = 1'b1;
                n_count                = r_count + IDX_W'(1);
            end
            if (i_cmd.walk_last) begin
                n_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
            r_ready <= 1'b0;
        end else begin
            r_used  <= n_used;
            r_count <= n_count;
            r_ready <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos[pos_waddr] <= pos_wdata;
        end
    end

    // letter -> 'A' + cipher position, everything else unchanged
    assign dec_char = fold.hit ? (UPPER_A + 8'(r_pos[fold.idx])) : s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.msg_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.msg_load) begin
            r_out_char <= r_ready ? dec_char : s_axis_tdata;
            r_out_nr   <= !r_ready;
        end
    end

    assign m_axis_tvalid      = r_out_valid;
    assign m_axis_tdata       = r_out_char;
    assign m_axis_tuser       = r_out_nr;
    assign o_stat.out_full    = r_out_valid;
    assign o_stat.table_ready = r_ready;

endmodule

// File: design/keyword_cipher_decoder_unit.sv
// Keyword substitution cipher decoder. Each input word carries a mode in
// s_axis_tuser (0 key byte, 1 end of key, 2 ciphertext byte, 3 ignored) and
// a byte in s_axis_tdata. Key bytes build the cipher alphabet: the first
// appearance of each letter, case folded, takes the next position, other
// bytes are skipped. End of key fills the unused letters in alphabetical
// order and marks the table ready; s_axis_tready is low during this walk,
// as the single position-store write port visits one letter per cycle.
// Key bytes and mode-3 words give no output. A ciphertext byte gives
// one output word, registered and shown in the next cycle: an upper-case
// plaintext letter for a letter of either case, the
// byte itself otherwise. Before the table is ready the byte is echoed with
// m_axis_tuser (not_ready) set. A key byte after a ready table starts a new
// key. One output register holds the result; input is taken while it is
// full only if the sink takes that word in the same cycle.
module keyword_cipher_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic [1:0] s_axis_tuser,   // [1:0] mode
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tuser    // [0] not_ready
);
    import kcd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    kcd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .m_axis_tready (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    kcd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_stat        (stat)
    );

    // no input taken while the end-of-key walk runs
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !s_axis_tready)
        else $error("input accepted during end-of-key walk");

    // the walk always finishes with a ready table
    a_walk_ends_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_last |=> stat.table_ready)
        else $error("table not ready after end-of-key walk");

    // every accepted ciphertext word shows up at the output next cycle
    a_msg_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_MSG) |=> m_axis_tvalid)
        else $error("decoded word missing");

    // a word marked not ready never comes from a ready table
    a_nr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.msg_load |=> (m_axis_tuser == !$past(stat.table_ready)))
        else $error("not_ready flag does not match table state");

endmodule
